>>> src/qph_pkg.sv
// Shared constants and types for the quadratic probe occupancy table.
package qph_pkg;

	// Table storage and field widths.
	localparam int TABLE_DEPTH = 4096;
	localparam int ADDR_W      = $clog2(TABLE_DEPTH);
	localparam int CNT_W       = 13;
	localparam int ID_BYTES    = 10;
	localparam int IDX_W       = $clog2(ID_BYTES + 1);
	localparam int KEY_W       = 64;
	localparam int KBIT_W      = $clog2(KEY_W);

	// Stream payload layout.
	localparam int IN_W   = 96;
	localparam int OUT_W  = 32;
	localparam int SLOT_W = 12;

	// Configuration register indexes, reset values and clamping bounds.
	localparam logic REG_TABLE_SIZE  = 1'b0;
	localparam logic REG_PROBE_LIMIT = 1'b1;
	localparam logic [CNT_W-1:0] TABLE_SIZE_RST  = 13'd4093;
	localparam logic [CNT_W-1:0] PROBE_LIMIT_RST = 13'd10;
	localparam logic [CNT_W-1:0] SIZE_MIN  = 13'd2;
	localparam logic [CNT_W-1:0] SIZE_MAX  = CNT_W'(TABLE_DEPTH);
	localparam logic [CNT_W-1:0] LIMIT_CAP = 13'd4096;

	// Operation codes carried on tuser.
	localparam logic OP_INSERT = 1'b0;
	localparam logic OP_QUERY  = 1'b1;

	typedef logic [7:0] id_byte_t;

endpackage

>>> src/quadratic_probe_hash_occupancy.sv
// Top level of the quadratic probe occupancy table with its sequencer and slot memory.

// After reset the block first clears its 4096-entry slot memory, one entry a cycle,
// so s_tready stays low until the pass ends; configuration writes are taken meanwhile.
// An insert multiplies the identifier bytes into a 64-bit key, one nonzero byte at a
// time up to the first zero byte, reduces the key modulo the table size in a
// bit-serial restoring divider, then probes the quadratic sequence, each probe a
// memory read followed by a check and update. A query runs the same divider on the
// 12-bit start slot only and the same probe walk. The walk ends on an empty slot
// or on the probe bound. A new item is taken once the previous one has finished; a
// finished result waits in the output register while the next item is accepted.
module quadratic_probe_hash_occupancy (
	input  logic                      clk,
	input  logic                      arst_n,
	// Configuration write port.
	input  logic                      cfg_we,
	input  logic                      cfg_index,
	input  logic [qph_pkg::CNT_W-1:0] cfg_data,
	// Input stream.
	input  logic                      s_tvalid,
	output logic                      s_tready,
	// tdata: id_byte_0 .. id_byte_9 (8 bits each), start_slot (12), zero fill (4)
	input  logic [qph_pkg::IN_W-1:0]  s_tdata,
	// tuser: operation
	input  logic                      s_tuser,
	// Output stream.
	output logic                      m_tvalid,
	input  logic                      m_tready,
	// tdata: slot (12), placed (1), probe_count (13), zero fill (6)
	output logic [qph_pkg::OUT_W-1:0] m_tdata
);

	typedef enum logic [2:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_KEY,
		ST_MOD,
		ST_READ,
		ST_CHECK,
		ST_FINISH
	} state_t;

	state_t state_q;

	// Configuration registers.
	logic [qph_pkg::CNT_W-1:0] table_size_q;
	logic [qph_pkg::CNT_W-1:0] probe_limit_q;

	// Working registers.
	logic                       op_q;
	qph_pkg::id_byte_t          id_q [qph_pkg::ID_BYTES];
	logic [qph_pkg::IDX_W-1:0]  idx_q;
	logic [qph_pkg::KEY_W-1:0]  key_q;
	logic [qph_pkg::KBIT_W-1:0] kbit_q;
	logic [qph_pkg::CNT_W-1:0]  rem_q;
	logic [qph_pkg::CNT_W-1:0]  size_q;
	logic [qph_pkg::CNT_W-1:0]  limit_q;
	logic [qph_pkg::CNT_W-1:0]  pos_q;
	logic [qph_pkg::CNT_W-1:0]  step_q;
	logic [qph_pkg::CNT_W-1:0]  count_q;
	logic                       placed_q;
	logic [qph_pkg::ADDR_W-1:0] clr_q;
	logic                       m_tvalid_q;
	logic [qph_pkg::OUT_W-1:0]  m_tdata_q;

	// Slot memory.
	logic                       mem [qph_pkg::TABLE_DEPTH];
	logic                       rd_q;
	logic                       mem_we;
	logic [qph_pkg::ADDR_W-1:0] mem_waddr;
	logic                       mem_wdata;

	// Effective sizes after clamping.
	logic [qph_pkg::CNT_W-1:0] size_eff;
	logic [qph_pkg::CNT_W-1:0] limit_eff;

	// Shared arithmetic.
	logic [qph_pkg::CNT_W:0]   div_trial;
	logic [qph_pkg::CNT_W:0]   pos_sum;
	logic [qph_pkg::CNT_W:0]   step_sum;
	logic [qph_pkg::CNT_W-1:0] pos_next;
	logic [qph_pkg::CNT_W-1:0] step_next;
	qph_pkg::id_byte_t         cur_byte;
	logic                      accept;

	always_comb begin
		size_eff = table_size_q;
		if (table_size_q < qph_pkg::SIZE_MIN) begin
			size_eff = qph_pkg::SIZE_MIN;
		end else if (table_size_q > qph_pkg::SIZE_MAX) begin
			size_eff = qph_pkg::SIZE_MAX;
		end
		limit_eff = (probe_limit_q > qph_pkg::LIMIT_CAP) ? qph_pkg::LIMIT_CAP : probe_limit_q;
	end

	// Restoring divider step and the incremental quadratic offset.
	always_comb begin
		div_trial = {rem_q, key_q[qph_pkg::KEY_W-1]};
		pos_sum   = {1'b0, pos_q} + {1'b0, step_q};
		pos_next  = (pos_sum >= {1'b0, size_q}) ? qph_pkg::CNT_W'(pos_sum - {1'b0, size_q})
		                                        : qph_pkg::CNT_W'(pos_sum);
		step_sum  = {1'b0, step_q} + (qph_pkg::CNT_W + 1)'(2);
		step_next = (step_sum >= {1'b0, size_q}) ? qph_pkg::CNT_W'(step_sum - {1'b0, size_q})
		                                         : qph_pkg::CNT_W'(step_sum);
		cur_byte  = (idx_q < qph_pkg::IDX_W'(qph_pkg::ID_BYTES)) ? id_q[idx_q] : 8'd0;
	end

	assign s_tready = (state_q == ST_IDLE);
	assign accept   = s_tvalid && s_tready;
	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = m_tdata_q;

	// Memory write control: clearing pass, or marking a slot on placement.
	always_comb begin
		mem_we    = 1'b0;
		mem_waddr = clr_q;
		mem_wdata = 1'b0;
		if (state_q == ST_CLEAR) begin
			mem_we = 1'b1;
		end else if (state_q == ST_CHECK && op_q == qph_pkg::OP_INSERT && !rd_q) begin
			mem_we    = 1'b1;
			mem_waddr = pos_q[qph_pkg::ADDR_W-1:0];
			mem_wdata = 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem[mem_waddr] <= mem_wdata;
		end
		rd_q <= mem[pos_q[qph_pkg::ADDR_W-1:0]];
	end

	// Configuration registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			table_size_q  <= qph_pkg::TABLE_SIZE_RST;
			probe_limit_q <= qph_pkg::PROBE_LIMIT_RST;
		end else if (cfg_we) begin
			unique case (cfg_index)
				qph_pkg::REG_TABLE_SIZE:  table_size_q  <= cfg_data;
				qph_pkg::REG_PROBE_LIMIT: probe_limit_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// Sequencer with registered outputs.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_CLEAR;
			clr_q      <= '0;
			m_tvalid_q <= 1'b0;
		end else begin
			if (m_tvalid_q && m_tready && state_q != ST_FINISH) begin
				m_tvalid_q <= 1'b0;
			end
			unique case (state_q)
				ST_CLEAR: begin
					clr_q <= clr_q + 1'b1;
					if (clr_q == qph_pkg::ADDR_W'(qph_pkg::TABLE_DEPTH - 1)) begin
						state_q <= ST_IDLE;
					end
				end
				ST_IDLE: begin
					if (accept) begin
						op_q    <= s_tuser;
						size_q  <= size_eff;
						limit_q <= limit_eff;
						for (int i = 0; i < qph_pkg::ID_BYTES; i++) begin
							id_q[i] <= s_tdata[8*i +: 8];
						end
						idx_q  <= '0;
						kbit_q <= '0;
						rem_q  <= '0;
						if (s_tuser == qph_pkg::OP_INSERT) begin
							key_q   <= qph_pkg::KEY_W'(1);
							state_q <= ST_KEY;
						end else begin
							key_q   <= {s_tdata[8*qph_pkg::ID_BYTES +: qph_pkg::SLOT_W],
							            {(qph_pkg::KEY_W - qph_pkg::SLOT_W){1'b0}}};
							kbit_q  <= qph_pkg::KBIT_W'(qph_pkg::KEY_W - qph_pkg::SLOT_W);
							state_q <= ST_MOD;
						end
					end
				end
				// Key product, one byte a cycle up to the first zero byte.
				ST_KEY: begin
					if (cur_byte == 8'd0) begin
						state_q <= ST_MOD;
					end else begin
						key_q <= key_q * qph_pkg::KEY_W'(cur_byte);
						idx_q <= idx_q + 1'b1;
					end
				end
				// Key modulo table size, one dividend bit a cycle.
				ST_MOD: begin
					rem_q <= (div_trial >= {1'b0, size_q})
					         ? qph_pkg::CNT_W'(div_trial - {1'b0, size_q})
					         : qph_pkg::CNT_W'(div_trial);
					key_q  <= {key_q[qph_pkg::KEY_W-2:0], 1'b0};
					kbit_q <= kbit_q + 1'b1;
					if (kbit_q == qph_pkg::KBIT_W'(qph_pkg::KEY_W - 1)) begin
						state_q  <= ST_READ;
						step_q   <= qph_pkg::CNT_W'(1);
						placed_q <= 1'b0;
						count_q  <= (op_q == qph_pkg::OP_INSERT) ? '0 : qph_pkg::CNT_W'(1);
						pos_q    <= (div_trial >= {1'b0, size_q})
						            ? qph_pkg::CNT_W'(div_trial - {1'b0, size_q})
						            : qph_pkg::CNT_W'(div_trial);
					end
				end
				// Loop bound test; the slot is read at this edge.
				ST_READ: begin
					if (op_q == qph_pkg::OP_INSERT && count_q >= size_q) begin
						state_q <= ST_FINISH;
					end else if (op_q == qph_pkg::OP_QUERY && count_q > limit_q) begin
						state_q <= ST_FINISH;
					end else begin
						state_q <= ST_CHECK;
					end
				end
				ST_CHECK: begin
					if (!rd_q) begin
						placed_q <= (op_q == qph_pkg::OP_INSERT);
						state_q  <= ST_FINISH;
					end else begin
						pos_q   <= pos_next;
						step_q  <= step_next;
						count_q <= count_q + 1'b1;
						state_q <= ST_READ;
					end
				end
				ST_FINISH: begin
					if (!m_tvalid_q || m_tready) begin
						m_tvalid_q <= 1'b1;
						m_tdata_q  <= {6'd0, count_q, placed_q,
						               placed_q ? pos_q[qph_pkg::SLOT_W-1:0] : 12'd0};
						state_q    <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

`ifndef NO_ASSERTIONS
	// The remainder stays reduced below the table size while dividing.
	assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_MOD |-> rem_q < size_q)
		else $error("remainder not reduced");
	// Probe position and offset stay inside the table.
	assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_CHECK |-> (pos_q < size_q && step_q < size_q))
		else $error("probe position out of range");
	// A placed insert never reports as many failed tries as the table size.
	assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_FINISH && placed_q) |-> count_q < size_q)
		else $error("placement after exhausted probes");
	// No item is taken during the clearing pass.
	assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_CLEAR |-> !s_tready)
		else $error("accepting during clear");
`endif

endmodule

>>> verif/tb_quadratic_probe_hash_occupancy.sv
// Testbench for the quadratic probe occupancy table: stream stimulus with a scoreboard.
`timescale 1ns / 100ps

module tb_quadratic_probe_hash_occupancy;

	localparam int WATCHDOG_LIMIT = 200000;

	typedef struct packed {
		logic         op;
		logic [95:0]  data;
	} probe_item_t;

	// Packed from the highest bit down, matching the result tdata layout.
	typedef struct packed {
		logic [12:0] count;
		logic        placed;
		logic [11:0] slot;
	} probe_result_t;

	logic clk;
	logic arst_n;
	logic cfg_we;
	logic cfg_index;
	logic [qph_pkg::CNT_W-1:0] cfg_data;
	logic s_tvalid;
	logic s_tready;
	logic [qph_pkg::IN_W-1:0] s_tdata;
	logic s_tuser;
	logic m_tvalid;
	logic m_tready;
	logic [qph_pkg::OUT_W-1:0] m_tdata;

	quadratic_probe_hash_occupancy dut (
		.clk(clk), .arst_n(arst_n),
		.cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata)
	);

	// Predictor state, kept apart from the block.
	bit                        occ_map [qph_pkg::TABLE_DEPTH];
	logic [qph_pkg::CNT_W-1:0] size_reg;
	logic [qph_pkg::CNT_W-1:0] limit_reg;

	probe_item_t   pending_items [$];
	probe_result_t expected_results [$];
	int  send_idle_pct;
	int  recv_stall_pct;
	int  failures;
	int  quiet_cycles;

	// Work out the result of one accepted transaction and update the map.
	function automatic probe_result_t predict_probe(probe_item_t it);
		probe_result_t r;
		int unsigned sz;
		int unsigned lim;
		int unsigned home;
		int unsigned pos;
		int unsigned cnt;
		longint unsigned key;
		longint unsigned f;
		logic [7:0] b;
		sz = size_reg;
		if (sz < 2) sz = 2;
		if (sz > qph_pkg::TABLE_DEPTH) sz = qph_pkg::TABLE_DEPTH;
		r = '0;
		cnt = 0;
		if (it.op == qph_pkg::OP_INSERT) begin
			key = 1;
			for (int i = 0; i < qph_pkg::ID_BYTES; i++) begin
				b = it.data[8*i +: 8];
				if (b == 0) break;
				key = key * b;
			end
			home = 32'(key % sz);
			pos = home;
			f = 1;
			while (cnt < sz) begin
				if (!occ_map[pos]) begin
					occ_map[pos] = 1;
					r.slot = 12'(pos);
					r.placed = 1;
					break;
				end
				pos = 32'((home + f * f) % sz);
				f++;
				cnt++;
			end
		end else begin
			lim = limit_reg;
			if (lim > 4096) lim = 4096;
			home = it.data[80 +: 12] % sz;
			pos = home;
			f = 1;
			cnt = 1;
			while (cnt <= lim && occ_map[pos]) begin
				pos = 32'((home + f * f) % sz);
				f++;
				cnt++;
			end
		end
		r.count = 13'(cnt);
		return r;
	endfunction

	// Clock generation.
	initial begin
		clk = 0;
		forever #1 clk = ~clk;
	end

	// Driver: offers queued transactions with random idle gaps.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s_tvalid <= 0;
			s_tdata <= '0;
			s_tuser <= 0;
		end else begin
			if (s_tvalid && s_tready) begin
				expected_results.insert(expected_results.size(),
					predict_probe({s_tuser, s_tdata}));
			end
			if (!s_tvalid || s_tready) begin
				if (pending_items.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
					s_tvalid <= 1;
					s_tuser <= pending_items[0].op;
					s_tdata <= pending_items[0].data;
					void'(pending_items.pop_front());
				end else begin
					s_tvalid <= 0;
				end
			end
		end
	end

	// Monitor: compares each result transaction with the oldest expectation.
	always @(posedge clk or negedge arst_n) begin
		probe_result_t got;
		probe_result_t exp_r;
		if (!arst_n) begin
			m_tready <= 0;
			quiet_cycles <= 0;
		end else begin
			m_tready <= ($urandom_range(99) >= recv_stall_pct);
			if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
				quiet_cycles <= 0;
			else
				quiet_cycles <= quiet_cycles + 1;
			if (m_tvalid && m_tready) begin
				got = m_tdata[25:0];
				if (expected_results.size() == 0) begin
					$display("%0t: unexpected result %h", $realtime, got);
					failures++;
				end else begin
					exp_r = expected_results.pop_front();
					if (got.slot !== exp_r.slot || got.placed !== exp_r.placed
						|| got.count !== exp_r.count) begin
						$display("%0t: expected slot %0d placed %0d count %0d, got %0d %0d %0d",
							$realtime, exp_r.slot, exp_r.placed, exp_r.count,
							got.slot, got.placed, got.count);
						failures++;
					end
				end
			end
		end
	end

	// Watchdog on cycles with no transaction on either side.
	always @(posedge clk) begin
		if (quiet_cycles >= WATCHDOG_LIMIT) begin
			$display("FAIL quadratic_probe_hash_occupancy");
			$finish;
		end
	end

	task automatic queue_insert(input logic [7:0] bytes [10]);
		probe_item_t it;
		it.op = qph_pkg::OP_INSERT;
		it.data = '0;
		for (int i = 0; i < 10; i++) it.data[8*i +: 8] = bytes[i];
		it.data[80 +: 12] = 12'($urandom);
		pending_items.insert(pending_items.size(), it);
	endtask

	task automatic queue_query(input logic [11:0] start);
		probe_item_t it;
		it.op = qph_pkg::OP_QUERY;
		it.data = {$urandom, $urandom, $urandom};
		it.data[95:92] = '0;
		it.data[80 +: 12] = start;
		pending_items.insert(pending_items.size(), it);
	endtask

	// Random identifier: a nonzero run of random length 0 to 10, ending in a zero byte when shorter than ten.
	task automatic queue_random_insert();
		logic [7:0] bytes [10];
		int len;
		len = $urandom_range(10);
		for (int i = 0; i < 10; i++) begin
			bytes[i] = 8'($urandom);
			if (i < len && bytes[i] == 0) bytes[i] = 1;
			if (i == len) bytes[i] = 0;
		end
		queue_insert(bytes);
	endtask

	// Write one register; the block is idle when this is called.
	task automatic write_reg(input logic idx, input logic [qph_pkg::CNT_W-1:0] val);
		cfg_we <= 1;
		cfg_index <= idx;
		cfg_data <= val;
		@(posedge clk);
		cfg_we <= 0;
		if (idx == qph_pkg::REG_TABLE_SIZE) size_reg = val;
		else limit_reg = val;
		@(posedge clk);
	endtask

	// Let the queued transactions drain and the block settle.
	task automatic drain();
		while (pending_items.size() > 0 || s_tvalid || expected_results.size() > 0)
			@(posedge clk);
		repeat (100) @(posedge clk);
	endtask

	// Random phase with a given table size, limit and idle mix.
	task automatic run_phase(input int sz, input int lim, input int n,
		input int idle, input int stall);
		write_reg(qph_pkg::REG_TABLE_SIZE, qph_pkg::CNT_W'(sz));
		write_reg(qph_pkg::REG_PROBE_LIMIT, qph_pkg::CNT_W'(lim));
		send_idle_pct = idle;
		recv_stall_pct = stall;
		for (int i = 0; i < n; i++) begin
			if ($urandom_range(99) < 60) queue_random_insert();
			else queue_query(12'($urandom));
		end
		drain();
	endtask

	initial begin
		logic [7:0] bytes [10];
		arst_n = 0;
		cfg_we = 0;
		cfg_index = 0;
		cfg_data = '0;
		failures = 0;
		send_idle_pct = 0;
		recv_stall_pct = 0;
		size_reg = qph_pkg::TABLE_SIZE_RST;
		limit_reg = qph_pkg::PROBE_LIMIT_RST;
		foreach (occ_map[i]) occ_map[i] = 0;
		repeat (12) @(posedge clk);
		arst_n <= 1;
		@(posedge clk);

		// Directed: reset sizes, extreme bytes, first zero byte, queries beyond the table.
		for (int i = 0; i < 10; i++) bytes[i] = 8'hFF;
		queue_insert(bytes);
		queue_insert(bytes);
		for (int i = 0; i < 10; i++) bytes[i] = 0;
		queue_insert(bytes);
		bytes[0] = 8'h01; bytes[1] = 8'h80; bytes[2] = 0; bytes[3] = 8'hFF;
		queue_insert(bytes);
		queue_query(12'd0);
		queue_query(12'hFFF);
		queue_query(12'd1);
		drain();

		// Small table below the minimum: fill it, fail, and query past the limit.
		write_reg(qph_pkg::REG_TABLE_SIZE, 13'd0);
		write_reg(qph_pkg::REG_PROBE_LIMIT, 13'd0);
		for (int k = 0; k < 4; k++) queue_random_insert();
		queue_query(12'hFFF);
		drain();
		write_reg(qph_pkg::REG_PROBE_LIMIT, 13'h1FFF);
		queue_query(12'd3);
		for (int i = 0; i < 10; i++) bytes[i] = 8'hAA;
		queue_insert(bytes);
		drain();

		// Oversized table acts as full depth; large limit capped.
		write_reg(qph_pkg::REG_TABLE_SIZE, 13'h1FFF);
		queue_query(12'hABC);
		queue_insert(bytes);
		queue_query(12'hFFF);
		drain();

		// Random phases across sizes and idle mixes.
		run_phase(7, 20, 150, 0, 0);
		run_phase(31, 4096, 200, 56, 0);
		run_phase(2, 1, 60, 0, 56);
		run_phase(4096, 10, 200, 26, 26);
		run_phase(13, 5, 150, 0, 0);
		run_phase($urandom_range(2, 4096), $urandom_range(0, 4096), 150, 56, 56);
		run_phase(4093, 13'h1FFF, 140, 0, 0);

		if (failures == 0) begin
			$display("PASS quadratic_probe_hash_occupancy");
		end else begin
			$display("FAIL quadratic_probe_hash_occupancy");
		end
		$finish;
	end

endmodule
